// File: hdl/hspd_pkg.sv
// Package for the heater slow PWM drive: widths, codes and reset constants.
package hspd_pkg;

    localparam int unsigned PERIOD_W              = 16;
    localparam int unsigned LEVEL_W               = 8;
    localparam int unsigned POWER_W               = 7;
    localparam int unsigned COUNT_W               = 23;
    localparam int unsigned REQ_W                 = 2;
    localparam int unsigned MODE_W                = 2;

    localparam int unsigned S_TDATA_W             = 16;
    localparam int unsigned M_TDATA_W             = 8;
    localparam int unsigned APB_ADDR_W            = 3;
    localparam int unsigned APB_DATA_W            = 32;

    localparam int unsigned WINDOW_PERIODS_DEFAULT = 100;
    localparam logic [PERIOD_W-1:0] PERIOD_TICKS_RESET = 16'd20000;
    localparam logic [COUNT_W-1:0]  COUNT_MAX          = {COUNT_W{1'b1}};
    localparam logic [POWER_W-1:0]  LEVEL_FULL         = 7'd100;

    // register index of period_ticks
    localparam logic REG_PERIOD_TICKS = 1'b0;

    typedef enum logic [REQ_W-1:0] {
        REQ_LEVEL = 2'd0,
        REQ_TICK  = 2'd1,
        REQ_FAN   = 2'd2
    } req_type_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_OFF  = 2'd0,
        MODE_FULL = 2'd1,
        MODE_PWM  = 2'd2
    } drive_mode_t;

endpackage

// File: hdl/heater_slow_pwm_drive.sv
// Heater slow PWM drive: input stage, state update and result register.
// A transaction accepted into the input stage passes the state update into the result register.
// Throughput: one transaction per cycle while m_tready does not stall the output; the only loop
// is the state update (window counter add and compare, on-time multiply) in the second stage.
// aresetn is synchronous, active low: clears the pipeline valids and all drive
// state; period_ticks returns to 20000.
module heater_slow_pwm_drive #(
    parameter int unsigned WINDOW_PERIODS = hspd_pkg::WINDOW_PERIODS_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [hspd_pkg::S_TDATA_W-1:0]      s_tdata,  // [7:0] level_percent, [8] fan_running
    input  logic [hspd_pkg::REQ_W-1:0]          s_tuser,  // [1:0] req_type
    // result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [hspd_pkg::M_TDATA_W-1:0]      m_tdata,  // [0] heater_on, [7:1] power_level
    output logic [hspd_pkg::MODE_W-1:0]         m_tuser,  // [1:0] mode
    // configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [hspd_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [hspd_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [hspd_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import hspd_pkg::*;

    localparam int unsigned WP_W   = $clog2(WINDOW_PERIODS + 1);
    localparam int unsigned PROD_W = PERIOD_W + WP_W;
    localparam int unsigned CMP_W  = (PROD_W > COUNT_W) ? PROD_W : COUNT_W;

    // window length, clipped to what the counter holds
    function automatic logic [COUNT_W-1:0] window_len(input logic [PERIOD_W-1:0] period);
        logic [CMP_W-1:0] prod;
        prod = CMP_W'(WINDOW_PERIODS) * CMP_W'(period);
        if (prod > CMP_W'(COUNT_MAX)) begin
            window_len = COUNT_MAX;
        end else begin
            window_len = prod[COUNT_W-1:0];
        end
    endfunction

    // configuration
    logic [PERIOD_W-1:0] period_reg;
    logic [COUNT_W-1:0]  window_len_reg;
    logic                cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_PERIOD_TICKS);
    assign prdata = (paddr[2] == REG_PERIOD_TICKS) ? APB_DATA_W'(period_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg     <= PERIOD_TICKS_RESET;
            window_len_reg <= window_len(PERIOD_TICKS_RESET);
        end else if (cfg_wr) begin
            period_reg     <= pwdata[PERIOD_W-1:0];
            window_len_reg <= window_len(pwdata[PERIOD_W-1:0]);
        end
    end

    // pipeline handshake
    logic in_valid_reg;
    logic m_valid_reg;
    logic out_free;
    logic fire;

    assign out_free = !m_valid_reg || m_tready;
    assign fire     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    // input stage
    req_type_t           in_type_reg;
    logic [LEVEL_W-1:0]  in_level_reg;
    logic                in_fan_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_type_reg  <= req_type_t'(s_tuser);
            in_level_reg <= s_tdata[LEVEL_W-1:0];
            in_fan_reg   <= s_tdata[LEVEL_W];
        end
    end

    // drive state
    drive_mode_t         mode_reg,    mode_next;
    logic [POWER_W-1:0]  applied_reg, applied_next;
    logic [COUNT_W-1:0]  on_time_reg, on_time_next;
    logic [COUNT_W-1:0]  count_reg,   count_next;
    logic                relay_reg,   relay_next;
    logic                fan_ok_reg,  fan_ok_next;

    logic [LEVEL_W-1:0]  lvl_eff;
    logic [COUNT_W-1:0]  count_inc;

    assign lvl_eff   = fan_ok_reg ? in_level_reg : '0;
    assign count_inc = count_reg + COUNT_W'(1);

    always_comb begin
        mode_next    = mode_reg;
        applied_next = applied_reg;
        on_time_next = on_time_reg;
        count_next   = count_reg;
        relay_next   = relay_reg;
        fan_ok_next  = fan_ok_reg;
        case (in_type_reg)
            REQ_LEVEL: begin
                if (lvl_eff == '0) begin
                    if (mode_reg != MODE_OFF) begin
                        mode_next    = MODE_OFF;
                        applied_next = '0;
                    end
                end else if (lvl_eff >= LEVEL_W'(LEVEL_FULL)) begin
                    if (mode_reg != MODE_FULL) begin
                        mode_next    = MODE_FULL;
                        applied_next = LEVEL_FULL;
                    end
                end else if (lvl_eff[POWER_W-1:0] != applied_reg) begin
                    // a repeated PWM level keeps the on-time it already has
                    mode_next    = MODE_PWM;
                    applied_next = lvl_eff[POWER_W-1:0];
                    on_time_next = COUNT_W'(lvl_eff[POWER_W-1:0] * period_reg);
                end
            end
            REQ_TICK: begin
                count_next = (count_inc >= window_len_reg) ? '0 : count_inc;
                case (mode_reg)
                    MODE_OFF:  relay_next = 1'b0;
                    MODE_FULL: relay_next = 1'b1;
                    default:   relay_next = (count_next <= on_time_reg);
                endcase
            end
            REQ_FAN: begin
                fan_ok_next = in_fan_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= MODE_OFF;
            applied_reg <= '0;
            on_time_reg <= '0;
            count_reg   <= '0;
            relay_reg   <= 1'b0;
            fan_ok_reg  <= 1'b0;
        end else if (fire) begin
            mode_reg    <= mode_next;
            applied_reg <= applied_next;
            on_time_reg <= on_time_next;
            count_reg   <= count_next;
            relay_reg   <= relay_next;
            fan_ok_reg  <= fan_ok_next;
        end
    end

    // result register
    logic [M_TDATA_W-1:0] m_data_reg;
    logic [MODE_W-1:0]    m_user_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            m_data_reg <= {applied_next, relay_next};
            m_user_reg <= mode_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    // state invariants
    a_off_level : assert property (@(posedge aclk) disable iff (!aresetn)
        mode_reg == MODE_OFF |-> applied_reg == '0)
        else $error("off mode with nonzero applied level");

    a_full_level : assert property (@(posedge aclk) disable iff (!aresetn)
        mode_reg == MODE_FULL |-> applied_reg == LEVEL_FULL)
        else $error("full mode with applied level other than 100");

    a_pwm_level : assert property (@(posedge aclk) disable iff (!aresetn)
        mode_reg == MODE_PWM |-> (applied_reg != '0 && applied_reg < LEVEL_FULL))
        else $error("PWM mode with applied level outside 1..99");

    a_fan_interlock : assert property (@(posedge aclk) disable iff (!aresetn)
        fire && in_type_reg == REQ_LEVEL && !fan_ok_reg |=> mode_reg == MODE_OFF)
        else $error("level request applied while fan not running");

endmodule
